>>> src/frt_pkg.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker package
// Shared widths, constants, status codes and the context record type.
// ----------------------------------------------------------------------------
package frt_pkg;

	localparam int Entries    = 128;
	localparam int MaxChunks  = 16;
	localparam int SlotW      = $clog2(Entries);
	localparam int ChunkW     = $clog2(MaxChunks);
	localparam int LenAddrW   = SlotW + ChunkW;
	localparam int CLenW      = 11;
	localparam int TotW       = 15;
	localparam int HdrBytes   = 8;
	localparam int MaxPktLen  = 2055;

	localparam logic [15:0] TtlReset = 16'd5000;
	localparam logic [14:0] CapReset = 15'd32767;

	localparam logic [0:0] RegTtl = 1'b0;
	localparam logic [0:0] RegCap = 1'b1;

	localparam logic [1:0] StComplete = 2'd0;
	localparam logic [1:0] StWaiting  = 2'd1;
	localparam logic [1:0] StNoSlot   = 2'd2;
	localparam logic [1:0] StInvalid  = 2'd3;

	// Context record held in the context memory; valid lives in flip-flops.
	typedef struct packed {
		logic [31:0]          tag;
		logic [15:0]          session;
		logic [MaxChunks-1:0] rcvd;
		logic [31:0]          created;
	} ctx_t;

	localparam int CtxW = $bits(ctx_t);

endpackage

>>> src/fragment_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker
// Context table scanned from memory, chunk lengths stored and summed.
// ----------------------------------------------------------------------------
// Channel | Signals                                         | Direction
// in      | in_valid/in_ready, pkt_len .. now_ms            | into block
// out     | out_valid/out_ready, status, slot, reasm_len    | out of block
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data        | into block
//
// One item at a time. An invalid header goes straight to the result. Otherwise
// the table is read one slot per cycle, first for a match and, failing that,
// again for a free or expired slot. A complete group then reads each chunk
// length from the length memory in turn (S_SUM issues the read, S_SUMW adds).
// Reset clears all valid bits at once; no clearing pass is needed.
// A waiting result stalls only the next item, not the configuration port.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] pkt_len,
	input  logic [31:0] frag_tag,
	input  logic [7:0]  chunk_index,
	input  logic [7:0]  chunk_count,
	input  logic [15:0] session_tag,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [6:0]  slot,
	output logic [14:0] reasm_len,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int SW = frt_pkg::SlotW;
	localparam int CW = frt_pkg::ChunkW;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MATCH = 6'b000010,
		S_FREE  = 6'b000100,
		S_SUM   = 6'b001000,
		S_SUMW  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q;

	logic [15:0] ttl_q;
	logic [14:0] cap_q;
	logic [frt_pkg::Entries-1:0] valid_q;

	logic [11:0] plen_q;
	logic [31:0] tag_q;
	logic [CW-1:0] idx_q;
	logic [7:0]  cnt_q;
	logic [15:0] ses_q;
	logic [31:0] now_q;

	logic [SW:0]   scan_q;
	logic          rd_pend_q;
	logic [SW-1:0] rd_slot_q;
	logic [SW-1:0] slot_q;
	logic [CW:0]   sum_idx_q;
	logic [frt_pkg::TotW+1:0] sum_q;

	logic [1:0]  st_q;
	logic [6:0]  oslot_q;
	logic [14:0] olen_q;
	logic        ovalid_q;

	logic                  ctx_we;
	logic [SW-1:0]         ctx_waddr, ctx_raddr;
	frt_pkg::ctx_t         ctx_wdata, ctx_rdata;
	logic                  len_we;
	logic [frt_pkg::LenAddrW-1:0] len_waddr, len_raddr;
	logic [frt_pkg::CLenW-1:0]    len_wdata, len_rdata;

	frt_ram #(.Width(frt_pkg::CtxW), .Depth(frt_pkg::Entries)) u_ctx (
		.clk(clk), .we(ctx_we), .waddr(ctx_waddr), .wdata(ctx_wdata),
		.raddr(ctx_raddr), .rdata(ctx_rdata)
	);

	frt_ram #(.Width(frt_pkg::CLenW), .Depth(frt_pkg::Entries * frt_pkg::MaxChunks)) u_len (
		.clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
		.raddr(len_raddr), .rdata(len_rdata)
	);

	logic        hdr_bad;
	logic        live, expired, hit;
	logic [31:0] age;
	logic [frt_pkg::MaxChunks-1:0] rcvd_new, full_mask;

	assign hdr_bad = (pkt_len < 12'(frt_pkg::HdrBytes)) || (pkt_len > 12'(frt_pkg::MaxPktLen))
		|| (chunk_count == 8'd0) || (chunk_count > 8'(frt_pkg::MaxChunks))
		|| (chunk_index >= chunk_count);

	assign age     = now_q - ctx_rdata.created;
	assign expired = age > {16'd0, ttl_q};
	assign live    = valid_q[rd_slot_q] && !expired;
	assign hit     = live && ctx_rdata.tag == tag_q && ctx_rdata.session == ses_q;

	always_comb begin
		full_mask = '0;
		for (int i = 0; i < frt_pkg::MaxChunks; i++) begin
			full_mask[i] = (8'(i) < cnt_q);
		end
	end

	assign in_ready  = (state_q == S_IDLE) && !ovalid_q;
	assign cfg_ready = 1'b1;
	assign out_valid = ovalid_q;
	assign status    = st_q;
	assign slot      = oslot_q;
	assign reasm_len = olen_q;

	assign ctx_raddr = scan_q[SW-1:0];
	assign len_raddr = {slot_q, sum_idx_q[CW-1:0]};
	assign len_waddr = {rd_slot_q, idx_q};
	assign len_wdata = frt_pkg::CLenW'(plen_q - 12'(frt_pkg::HdrBytes));
	assign ctx_waddr = rd_slot_q;

	always_comb begin
		ctx_we    = 1'b0;
		len_we    = 1'b0;
		ctx_wdata = ctx_rdata;
		rcvd_new  = '0;
		if (rd_pend_q && state_q == S_MATCH && hit) begin
			rcvd_new  = ctx_rdata.rcvd | (frt_pkg::MaxChunks'(1) << idx_q);
			ctx_wdata.rcvd = rcvd_new;
			ctx_we = 1'b1;
			len_we = 1'b1;
		end else if (rd_pend_q && state_q == S_FREE && !live) begin
			rcvd_new  = frt_pkg::MaxChunks'(1) << idx_q;
			ctx_wdata.tag     = tag_q;
			ctx_wdata.session = ses_q;
			ctx_wdata.created = now_q;
			ctx_wdata.rcvd    = rcvd_new;
			ctx_we = 1'b1;
			len_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ttl_q     <= frt_pkg::TtlReset;
			cap_q     <= frt_pkg::CapReset;
			valid_q   <= '0;
			ovalid_q  <= 1'b0;
			rd_pend_q <= 1'b0;
			scan_q    <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					frt_pkg::RegTtl: ttl_q <= cfg_data;
					frt_pkg::RegCap: cap_q <= cfg_data[14:0];
					default: ;
				endcase
			end
			if (ovalid_q && out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						plen_q <= pkt_len;
						tag_q  <= frag_tag;
						idx_q  <= chunk_index[CW-1:0];
						cnt_q  <= chunk_count;
						ses_q  <= session_tag;
						now_q  <= now_ms;
						scan_q <= '0;
						rd_pend_q <= 1'b0;
						if (hdr_bad) begin
							st_q    <= frt_pkg::StInvalid;
							oslot_q <= '0;
							olen_q  <= '0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_MATCH;
						end
					end
				end
				S_MATCH, S_FREE: begin
					rd_pend_q <= 1'b0;
					if (rd_pend_q && ctx_we) begin
						slot_q  <= rd_slot_q;
						oslot_q <= 7'(rd_slot_q);
						if (state_q == S_FREE) begin
							valid_q[rd_slot_q] <= 1'b1;
						end
						if ((rcvd_new & full_mask) == full_mask) begin
							sum_idx_q <= '0;
							sum_q     <= '0;
							state_q   <= S_SUM;
						end else begin
							st_q    <= frt_pkg::StWaiting;
							olen_q  <= '0;
							state_q <= S_OUT;
						end
					end else if (rd_pend_q && rd_slot_q == SW'(frt_pkg::Entries - 1)) begin
						scan_q <= '0;
						if (state_q == S_MATCH) begin
							state_q <= S_FREE;
						end else begin
							st_q    <= frt_pkg::StNoSlot;
							oslot_q <= '0;
							olen_q  <= '0;
							state_q <= S_OUT;
						end
					end else if (!scan_q[SW]) begin
						rd_slot_q <= scan_q[SW-1:0];
						rd_pend_q <= 1'b1;
						scan_q    <= scan_q + 1'b1;
					end
				end
				S_SUM: begin
					// Read for chunk sum_idx_q issued this cycle; data next cycle.
					state_q <= S_SUMW;
				end
				S_SUMW: begin
					sum_q <= sum_q + (frt_pkg::TotW + 2)'(len_rdata);
					if (sum_idx_q + 1'b1 == (CW + 1)'(cnt_q)) begin
						valid_q[slot_q] <= 1'b0;
						state_q <= S_OUT;
						if (sum_q + (frt_pkg::TotW + 2)'(len_rdata) > {2'b00, cap_q}) begin
							st_q   <= frt_pkg::StInvalid;
							olen_q <= '0;
						end else begin
							st_q   <= frt_pkg::StComplete;
							olen_q <= frt_pkg::TotW'(sum_q + (frt_pkg::TotW + 2)'(len_rdata));
						end
					end else begin
						sum_idx_q <= sum_idx_q + 1'b1;
						state_q   <= S_SUM;
					end
				end
				S_OUT: begin
					ovalid_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> src/frt_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module frt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembly tracker testbench
// Fragment headers are driven through the valid/ready input with random gaps
// while the result side stalls at random. A software copy of the context
// table predicts each verdict, and results are compared in order. Both
// registers are rewritten between phases, with the block idle.
// ----------------------------------------------------------------------------
module tb;

	typedef struct {
		logic [11:0] pkt_len;
		logic [31:0] frag_tag;
		logic [7:0]  chunk_index;
		logic [7:0]  chunk_count;
		logic [15:0] session_tag;
		logic [31:0] now_ms;
	} frag_t;

	typedef struct {
		logic [1:0]  status;
		logic [6:0]  slot;
		logic [14:0] reasm_len;
	} verdict_t;

	class reasm_scoreboard;
		bit               live[frt_pkg::Entries];
		logic [31:0]      ctx_tag[frt_pkg::Entries];
		logic [15:0]      ctx_session[frt_pkg::Entries];
		logic [31:0]      ctx_created[frt_pkg::Entries];
		logic [15:0]      ctx_rcvd[frt_pkg::Entries];
		logic [10:0]      ctx_len[frt_pkg::Entries][frt_pkg::MaxChunks];
		logic [15:0]      ttl;
		logic [14:0]      capacity;
		verdict_t         pending_verdicts[$];
		int               errors;
		int               n_status[4];

		function new();
			for (int s = 0; s < frt_pkg::Entries; s++) live[s] = 0;
			ttl = frt_pkg::TtlReset;
			capacity = frt_pkg::CapReset;
			errors = 0;
			for (int i = 0; i < 4; i++) n_status[i] = 0;
		endfunction

		function bit aged_out(int s, logic [31:0] now);
			logic [31:0] age;
			age = now - ctx_created[s];
			return age > {16'd0, ttl};
		endfunction

		function void note_fragment(frag_t f);
			verdict_t    v;
			int          sl;
			bit          hit;
			logic [16:0] need;
			int          sum;
			sl = 0;
			hit = 0;
			v.status = frt_pkg::StInvalid;
			v.slot = 0;
			v.reasm_len = 0;
			if (f.pkt_len >= frt_pkg::HdrBytes && f.pkt_len <= frt_pkg::MaxPktLen &&
				f.chunk_count != 0 && f.chunk_count <= frt_pkg::MaxChunks &&
				f.chunk_index < f.chunk_count) begin
				for (int s = 0; s < frt_pkg::Entries && !hit; s++)
					if (live[s] && !aged_out(s, f.now_ms) && ctx_tag[s] == f.frag_tag &&
						ctx_session[s] == f.session_tag) begin
						sl = s;
						hit = 1;
					end
				for (int s = 0; s < frt_pkg::Entries && !hit; s++)
					if (!live[s] || aged_out(s, f.now_ms)) begin
						sl = s;
						hit = 1;
						live[s] = 1;
						ctx_tag[s] = f.frag_tag;
						ctx_session[s] = f.session_tag;
						ctx_created[s] = f.now_ms;
						ctx_rcvd[s] = 0;
					end
				if (!hit) begin
					v.status = frt_pkg::StNoSlot;
				end else begin
					ctx_len[sl][f.chunk_index] = 11'(f.pkt_len - frt_pkg::HdrBytes);
					ctx_rcvd[sl][f.chunk_index] = 1'b1;
					need = (17'd1 << f.chunk_count) - 17'd1;
					v.slot = 7'(sl);
					if (({1'b0, ctx_rcvd[sl]} & need) != need) begin
						v.status = frt_pkg::StWaiting;
					end else begin
						sum = 0;
						for (int c = 0; c < f.chunk_count; c++) sum += ctx_len[sl][c];
						live[sl] = 0;
						if (sum > capacity) begin
							v.status = frt_pkg::StInvalid;
						end else begin
							v.status = frt_pkg::StComplete;
							v.reasm_len = 15'(sum);
						end
					end
				end
			end
			n_status[v.status]++;
			pending_verdicts.push_back(v);
		endfunction

		function void check_verdict(logic [1:0] st, logic [6:0] sl, logic [14:0] tl);
			verdict_t v;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result status=%0d slot=%0d reasm_len=%0d",
					$time, st, sl, tl);
				errors++;
				return;
			end
			v = pending_verdicts.pop_front();
			if (st !== v.status) begin
				$display("%0t: status expected %0d actual %0d", $time, v.status, st);
				errors++;
			end
			if (sl !== v.slot) begin
				$display("%0t: slot expected %0d actual %0d", $time, v.slot, sl);
				errors++;
			end
			if (tl !== v.reasm_len) begin
				$display("%0t: reasm_len expected %0d actual %0d", $time, v.reasm_len, tl);
				errors++;
			end
		endfunction

		function int pending();
			return pending_verdicts.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [11:0] pkt_len;
	logic [31:0] frag_tag;
	logic [7:0]  chunk_index;
	logic [7:0]  chunk_count;
	logic [15:0] session_tag;
	logic [31:0] now_ms;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [6:0]  slot;
	logic [14:0] reasm_len;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;

	reasm_scoreboard sb;
	frag_t           cur_frag;
	logic [31:0]     clock_ms;
	int              frags_sent;
	int              cycles;
	int              cfg_writes;
	bit              quiet;
	bit              hold_req;
	bit              hold_done;

	fragment_reassembly_tracker DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pkt_len(pkt_len), .frag_tag(frag_tag), .chunk_index(chunk_index),
		.chunk_count(chunk_count), .session_tag(session_tag), .now_ms(now_ms),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .slot(slot), .reasm_len(reasm_len),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 4000000) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_fragment(cur_frag);
		if (arst_n && out_valid && out_ready) sb.check_verdict(status, slot, reasm_len);
	end

	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		hold_done = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_left = 3000;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else if (quiet) begin
				out_ready = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready = 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 5);
				out_ready = 1'b0;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	task automatic push_frag(input frag_t f);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		cur_frag = f;
		pkt_len = f.pkt_len;
		frag_tag = f.frag_tag;
		chunk_index = f.chunk_index;
		chunk_count = f.chunk_count;
		session_tag = f.session_tag;
		now_ms = f.now_ms;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		frags_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send(input int plen, input logic [31:0] tag, input int idx, input int cnt,
		input logic [15:0] ses, input logic [31:0] now);
		frag_t f;
		f.pkt_len = 12'(plen);
		f.frag_tag = tag;
		f.chunk_index = 8'(idx);
		f.chunk_count = 8'(cnt);
		f.session_tag = ses;
		f.now_ms = now;
		push_frag(f);
	endtask

	task automatic drain();
		while (sb.pending() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == frt_pkg::RegTtl) sb.ttl = data;
		else sb.capacity = data[14:0];
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int pick_len();
		case ($urandom_range(0, 9))
			0: return frt_pkg::HdrBytes;
			1: return frt_pkg::MaxPktLen;
			default: return $urandom_range(frt_pkg::HdrBytes, frt_pkg::MaxPktLen);
		endcase
	endfunction

	task automatic tick_clock();
		if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
		else clock_ms += $urandom_range(0, 60);
	endtask

	task automatic send_group(inout logic [31:0] last_tag, inout logic [15:0] last_ses);
		int          n;
		int          order[frt_pkg::MaxChunks];
		int          j;
		int          t;
		logic [31:0] tag;
		logic [15:0] ses;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, frt_pkg::MaxChunks) :
			$urandom_range(1, 4);
		tag = ($urandom_range(0, 4) == 0) ? last_tag : $urandom;
		ses = ($urandom_range(0, 4) == 0) ? last_ses : 16'($urandom);
		last_tag = tag;
		last_ses = ses;
		for (int i = 0; i < n; i++) order[i] = i;
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < n; i++) begin
			tick_clock();
			if ($urandom_range(0, 9) == 0) continue;
			if ($urandom_range(0, 11) == 0)
				send(pick_len(), tag, order[i], n, ses, clock_ms);
			send(pick_len(), tag, order[i], ($urandom_range(0, 19) == 0) ?
				$urandom_range(order[i] + 1, frt_pkg::MaxChunks) : n, ses, clock_ms);
		end
	endtask

	task automatic random_phase(input int count);
		int          stop;
		logic [31:0] last_tag;
		logic [15:0] last_ses;
		frag_t       f;
		stop = frags_sent + count;
		last_tag = $urandom;
		last_ses = 16'($urandom);
		while (frags_sent < stop) begin
			if ($urandom_range(0, 99) < 12) begin
				tick_clock();
				f.pkt_len = 12'($urandom);
				f.frag_tag = $urandom;
				f.chunk_index = 8'($urandom);
				f.chunk_count = 8'($urandom);
				f.session_tag = 16'($urandom);
				f.now_ms = clock_ms;
				push_frag(f);
			end else begin
				send_group(last_tag, last_ses);
			end
		end
	endtask

	initial begin
		sb = new();
		frags_sent = 0;
		cfg_writes = 0;
		quiet = 0;
		hold_req = 0;
		clock_ms = 32'd1000;
		in_valid = 1'b0;
		pkt_len = '0;
		frag_tag = '0;
		chunk_index = '0;
		chunk_count = '0;
		session_tag = '0;
		now_ms = '0;
		cfg_valid = 1'b0;
		cfg_index = frt_pkg::RegTtl;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(0, 32'h1, 0, 1, 16'h1, clock_ms);
		send(7, 32'h1, 0, 1, 16'h1, clock_ms);
		send(4095, 32'h1, 0, 1, 16'h1, clock_ms);
		send(2056, 32'h1, 0, 1, 16'h1, clock_ms);
		send(100, 32'h1, 0, 0, 16'h1, clock_ms);
		send(100, 32'h1, 0, 17, 16'h1, clock_ms);
		send(100, 32'h1, 0, 255, 16'h1, clock_ms);
		send(100, 32'h1, 255, 16, 16'h1, clock_ms);
		send(100, 32'h1, 4, 4, 16'h1, clock_ms);
		send(8, 32'h0, 0, 1, 16'h0, clock_ms);
		send(2055, 32'hFFFF_FFFF, 0, 1, 16'hFFFF, clock_ms);
		send(100, 32'hB, 0, 3, 16'h5, clock_ms);
		send(200, 32'hB, 0, 3, 16'h5, clock_ms);
		send(50, 32'hB, 2, 3, 16'h5, clock_ms);
		send(60, 32'hB, 0, 2, 16'h6, clock_ms);
		send(70, 32'hB, 1, 2, 16'h5, clock_ms);
		send(300, 32'hC, 15, 16, 16'h7, clock_ms);
		drain();

		// Fill every context, overflow it, then free one and let all expire.
		write_reg(frt_pkg::RegTtl, 16'hFFFF);
		write_reg(frt_pkg::RegCap, 16'h7FFF);
		clock_ms += 32'd70000;
		for (int i = 0; i < frt_pkg::Entries + 2; i++)
			send(9 + i, 32'hA000_0000 + i, 0, 2, 16'(i), clock_ms);
		send(500, 32'hA000_0005, 1, 2, 16'd5, clock_ms);
		send(40, 32'hBEEF_0000, 1, 2, 16'd9, clock_ms);
		clock_ms += 32'd65536;
		send(40, 32'hBEEF_0001, 1, 2, 16'd9, clock_ms);
		drain();

		write_reg(frt_pkg::RegTtl, 16'd0);
		write_reg(frt_pkg::RegCap, 16'd0);
		random_phase(300);
		drain();

		write_reg(frt_pkg::RegTtl, frt_pkg::TtlReset);
		write_reg(frt_pkg::RegCap, {1'b0, frt_pkg::CapReset});
		clock_ms = 32'hFFFF_F000;
		hold_req = 1;
		random_phase(400);
		drain();

		write_reg(frt_pkg::RegTtl, 16'($urandom_range(50, 3000)));
		write_reg(frt_pkg::RegCap, 16'($urandom_range(1000, 20000)));
		random_phase(400);
		drain();

		write_reg(frt_pkg::RegTtl, 16'hFFFF);
		write_reg(frt_pkg::RegCap, 16'h7FFF);
		random_phase(400);
		drain();

		write_reg(frt_pkg::RegTtl, 16'($urandom_range(100, 800)));
		write_reg(frt_pkg::RegCap, 16'($urandom_range(4000, 32767)));
		quiet = 1;
		random_phase(350);
		drain();

		$display("Sent %0d fragments and made %0d register writes over %0d cycles.",
			frags_sent, cfg_writes, cycles);
		$display("Verdicts: %0d complete, %0d waiting, %0d no slot, %0d invalid.",
			sb.n_status[frt_pkg::StComplete], sb.n_status[frt_pkg::StWaiting],
			sb.n_status[frt_pkg::StNoSlot], sb.n_status[frt_pkg::StInvalid]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
src/frt_pkg.sv
src/frt_ram.sv
src/fragment_reassembly_tracker.sv
tb/tb.sv
